/* sv/arp_pkg.sv */
`timescale 1ns / 1ps

package arp_pkg;

   // default cache capacity (the directory holds twice this) and payload field widths
   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_BITS_DEF  = 48;
   localparam int TIME_BITS_DEF = 40;

   // register and result widths, register reset value and step limits
   localparam int CFG_BITS    = 7;
   localparam int TAG_BITS    = 3;
   localparam int NUM_BITS    = 8;
   localparam int CFG_RESET   = 64;
   localparam int STEP_SAT    = 128;
   localparam int STEP_LOG_MAX = 7;

   // list tags of a directory entry
   localparam logic [TAG_BITS-1:0] TAG_NONE = 3'd0;
   localparam logic [TAG_BITS-1:0] TAG_T1   = 3'd1;
   localparam logic [TAG_BITS-1:0] TAG_T2   = 3'd2;
   localparam logic [TAG_BITS-1:0] TAG_B1   = 3'd3;
   localparam logic [TAG_BITS-1:0] TAG_B2   = 3'd4;

   // register indexes
   localparam logic CSR_CACHE_ENTRIES = 1'b0;
   localparam logic CSR_RECENCY_LIMIT = 1'b1;

   // status of the scan unit toward the sequencer
   typedef struct packed {
      logic                done;
      logic                found;
      logic [TAG_BITS-1:0] tag;
      logic                free_vld;
   } scan_flags_type;

endpackage

/* sv/arp_dir.sv */
`timescale 1ns / 1ps

module arp_dir #(
   parameter int SLOTS     = 128,
   parameter int KEY_BITS  = 48,
   parameter int TIME_BITS = 40,
   parameter int AW        = 7
) (
   input  logic                          clock,
   input  logic [AW-1:0]                 addr,
   input  logic                          kt_we,
   input  logic                          tag_we,
   input  logic [KEY_BITS-1:0]           wkey,
   input  logic [TIME_BITS-1:0]          wtime,
   input  logic [arp_pkg::TAG_BITS-1:0]  wtag,
   output logic [KEY_BITS-1:0]           rd_key,
   output logic [TIME_BITS-1:0]          rd_time,
   output logic [arp_pkg::TAG_BITS-1:0]  rd_tag
);
   import arp_pkg::*;

   logic [KEY_BITS-1:0]  key_mem  [SLOTS];
   logic [TIME_BITS-1:0] time_mem [SLOTS];
   logic [TAG_BITS-1:0]  tag_mem  [SLOTS];

   // single port directory, registered read
   always_ff @(posedge clock) begin
      if (kt_we) begin
         key_mem[addr]  <= wkey;
         time_mem[addr] <= wtime;
      end
      if (tag_we) begin
         tag_mem[addr] <= wtag;
      end
      rd_key  <= key_mem[addr];
      rd_time <= time_mem[addr];
      rd_tag  <= tag_mem[addr];
   end

endmodule

/* sv/arp_scan.sv */
`timescale 1ns / 1ps

module arp_scan #(
   parameter int SLOTS     = 128,
   parameter int KEY_BITS  = 48,
   parameter int TIME_BITS = 40,
   parameter int AW        = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          lru_mode,
   input  logic [arp_pkg::TAG_BITS-1:0]  sel_tag,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [KEY_BITS-1:0]           rd_key,
   input  logic [TIME_BITS-1:0]          rd_time,
   input  logic [arp_pkg::TAG_BITS-1:0]  rd_tag,
   output logic [AW-1:0]                 addr,
   output arp_pkg::scan_flags_type       flags,
   output logic [AW-1:0]                 idx,
   output logic [AW-1:0]                 free_idx
);
   import arp_pkg::*;

   localparam logic [AW:0] LAST = (AW+1)'(SLOTS);

   logic                 running_ff, running_in;
   logic [AW:0]          cnt_ff, cnt_in;
   logic                 pv_ff, pv_in;
   logic [AW-1:0]        pidx_ff, pidx_in;
   logic                 done_ff, done_in;
   logic                 lru_ff, lru_in;
   logic [TAG_BITS-1:0]  sel_ff, sel_in;
   logic                 found_ff, found_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 free_vld_ff, free_vld_in;
   logic [AW-1:0]        free_idx_ff, free_idx_in;
   logic [TIME_BITS-1:0] best_time_ff, best_time_in;
   logic [KEY_BITS-1:0]  best_key_ff, best_key_in;
   logic                 older, take, free_take;

   // (time, key) order of the entry being read against the best so far
   assign older = (rd_time < best_time_ff) ||
                  ((rd_time == best_time_ff) && (rd_key < best_key_ff));

   always_comb begin
      take = 1'b0;
      if (pv_ff) begin
         if (lru_ff) begin
            take = (rd_tag == sel_ff) && (!found_ff || older);
         end else begin
            take = (rd_tag != TAG_NONE) && (rd_key == key) && !found_ff;
         end
      end
      free_take = pv_ff && !lru_ff && (rd_tag == TAG_NONE) && !free_vld_ff;
   end

   // address sweep and compare over the read stream
   always_comb begin
      running_in   = running_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      pidx_in      = pidx_ff;
      done_in      = running_ff && (cnt_ff == LAST) && !pv_ff;
      lru_in       = lru_ff;
      sel_in       = sel_ff;
      found_in     = found_ff;
      tag_in       = tag_ff;
      idx_in       = idx_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      best_time_in = best_time_ff;
      best_key_in  = best_key_ff;
      if (start) begin
         running_in  = 1'b1;
         cnt_in      = '0;
         lru_in      = lru_mode;
         sel_in      = sel_tag;
         found_in    = 1'b0;
         free_vld_in = 1'b0;
      end else begin
         if (running_ff) begin
            if (cnt_ff < LAST) begin
               cnt_in  = cnt_ff + 1'b1;
               pv_in   = 1'b1;
               pidx_in = cnt_ff[AW-1:0];
            end else if (!pv_ff) begin
               running_in = 1'b0;
            end
         end
         if (take) begin
            found_in     = 1'b1;
            tag_in       = rd_tag;
            idx_in       = pidx_ff;
            best_time_in = rd_time;
            best_key_in  = rd_key;
         end
         if (free_take) begin
            free_vld_in = 1'b1;
            free_idx_in = pidx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         pv_ff       <= 1'b0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
         free_vld_ff <= 1'b0;
         lru_ff      <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         running_ff  <= running_in;
         pv_ff       <= pv_in;
         done_ff     <= done_in;
         found_ff    <= found_in;
         free_vld_ff <= free_vld_in;
         lru_ff      <= lru_in;
         cnt_ff      <= cnt_in;
      end
      pidx_ff      <= pidx_in;
      sel_ff       <= sel_in;
      tag_ff       <= tag_in;
      idx_ff       <= idx_in;
      free_idx_ff  <= free_idx_in;
      best_time_ff <= best_time_in;
      best_key_ff  <= best_key_in;
   end

   assign addr           = cnt_ff[AW-1:0];
   assign flags.done     = done_ff;
   assign flags.found    = found_ff;
   assign flags.tag      = tag_ff;
   assign flags.free_vld = free_vld_ff;
   assign idx            = idx_ff;
   assign free_idx       = free_idx_ff;

endmodule

/* sv/adaptive_replacement_policy.sv */
`timescale 1ns / 1ps

// Adaptive replacement policy over a directory of 2*CAPACITY entries.
// The request channel (req_valid, req_stall) takes one page access word:
// req_page_key and req_access_time. The response channel (rsp_valid,
// rsp_stall) returns one word per access: rsp_was_hit, rsp_found_in
// (0 absent, 1 recent, 2 frequent, 3 recent ghost, 4 frequent ghost) and
// rsp_recent_target after the access.
// Every directory pass is one sweep of the single port directory memory
// through the shared scan/compare unit. An access takes one lookup pass,
// then one pass per eviction or demotion. A ghost hit first computes the
// adaptation step, by repeated addition when the other ghost list is
// larger. One access is worked at a time; req_stall is high until the
// response word is loaded. After reset the directory tags are swept empty,
// with req_stall high. Registers csr_index 0 (cache_entries) and 1
// (recency_limit) are written with csr_write, and reset to 64.
// When rsp_stall holds the response, the block keeps it; it can still take
// the next access, but waits in S_OUT until the response register is free.
module adaptive_replacement_policy #(
   parameter int CAPACITY  = arp_pkg::CAPACITY_DEF,
   parameter int KEY_BITS  = arp_pkg::KEY_BITS_DEF,
   parameter int TIME_BITS = arp_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [KEY_BITS-1:0]           req_page_key,
   input  logic [TIME_BITS-1:0]          req_access_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_was_hit,
   output logic [arp_pkg::TAG_BITS-1:0]  rsp_found_in,
   output logic [arp_pkg::CFG_BITS-1:0]  rsp_recent_target,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [arp_pkg::CFG_BITS-1:0]  csr_wdata
);
   import arp_pkg::*;

   localparam int SLOTS = 2 * CAPACITY;
   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int XW    = ((CW > NUM_BITS) ? CW : NUM_BITS) + 1;

   localparam logic [XW-1:0] CAP_X  = XW'(CAPACITY);
   localparam logic [XW-1:0] ONE_X  = XW'(1);
   localparam logic [XW-1:0] SAT_X  = XW'(STEP_SAT);
   localparam logic [2:0]    M_MAX  = 3'(STEP_LOG_MAX);
   localparam logic [AW-1:0] CLR_LAST = AW'(SLOTS - 1);

   // sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SEARCH = 4'd2;
   localparam logic [3:0] S_EVAL   = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_GHOST  = 4'd5;
   localparam logic [3:0] S_WRITE  = 4'd6;
   localparam logic [3:0] S_LRU    = 4'd7;
   localparam logic [3:0] S_DROP   = 4'd8;
   localparam logic [3:0] S_FULL   = 4'd9;
   localparam logic [3:0] S_TRIM   = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   // what an lru pass is for
   localparam logic [1:0] P_EVICT    = 2'd0;
   localparam logic [1:0] P_FALLBACK = 2'd1;
   localparam logic [1:0] P_TRIM1    = 2'd2;
   localparam logic [1:0] P_TRIM2    = 2'd3;

   logic [3:0]           state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [CFG_BITS-1:0]  cache_ff, limit_ff;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [CFG_BITS-1:0]  target_ff, target_in;
   logic [CW-1:0]        cnt_ff [4];
   logic [CW-1:0]        cnt_in [4];
   logic [TAG_BITS-1:0]  hit_tag_ff, hit_tag_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic                 free_vld_ff, free_vld_in;
   logic [AW-1:0]        free_idx_ff, free_idx_in;
   logic                 fb_done_ff, fb_done_in;
   logic [1:0]           purpose_ff, purpose_in;
   logic [TAG_BITS-1:0]  sel_ff, sel_in;
   logic [CW-1:0]        dvd_ff, dvd_in;
   logic [CW-1:0]        dvs_ff, dvs_in;
   logic [XW-1:0]        acc_ff, acc_in;
   logic [2:0]           m_ff, m_in;
   logic [AW-1:0]        wr_slot_ff, wr_slot_in;
   logic [TAG_BITS-1:0]  wr_old_ff, wr_old_in;
   logic [TAG_BITS-1:0]  wr_new_ff, wr_new_in;
   logic                 wr_kt_ff, wr_kt_in;
   logic [3:0]           wr_next_ff, wr_next_in;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [TAG_BITS-1:0]  rsp_found_ff;
   logic [CFG_BITS-1:0]  rsp_target_ff;
   logic                 out_load;

   logic                 scan_start, scan_lru;
   scan_flags_type       scan_flags;
   logic [AW-1:0]        scan_addr, scan_idx, scan_free_idx;
   logic [AW-1:0]        dir_addr;
   logic                 dir_kt_we, dir_tag_we;
   logic [TAG_BITS-1:0]  dir_wtag;
   logic [KEY_BITS-1:0]  rd_key;
   logic [TIME_BITS-1:0] rd_time;
   logic [TAG_BITS-1:0]  rd_tag;

   logic [XW-1:0] cfg_c_x, cfg_l_x, c_x, lim_x, target_x;
   logic [XW-1:0] nt1_x, nt2_x, nb1_x, nb2_x, total_x, t2cap_x;
   logic [XW-1:0] step_x, sum_x, ghost_x;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_ff <= CFG_BITS'(CFG_RESET);
         limit_ff <= CFG_BITS'(CFG_RESET);
      end else if (csr_write) begin
         case (csr_index)
            CSR_CACHE_ENTRIES: cache_ff <= csr_wdata;
            CSR_RECENCY_LIMIT: limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped size and limit, list counts
   always_comb begin
      cfg_c_x = XW'(cache_ff);
      cfg_l_x = XW'(limit_ff);
      if (cfg_c_x == '0) begin
         c_x = ONE_X;
      end else if (cfg_c_x > CAP_X) begin
         c_x = CAP_X;
      end else begin
         c_x = cfg_c_x;
      end
      if (cfg_l_x == '0) begin
         lim_x = ONE_X;
      end else if (cfg_l_x > c_x) begin
         lim_x = c_x;
      end else begin
         lim_x = cfg_l_x;
      end
      target_x = XW'(target_ff);
      nt1_x    = XW'(cnt_ff[0]);
      nt2_x    = XW'(cnt_ff[1]);
      nb1_x    = XW'(cnt_ff[2]);
      nb2_x    = XW'(cnt_ff[3]);
      total_x  = nt1_x + nt2_x + nb1_x + nb2_x;
      t2cap_x  = (c_x > target_x) ? (c_x - target_x) : '0;
      step_x   = (m_ff == M_MAX) ? SAT_X : (ONE_X << m_ff);
      sum_x    = target_x + step_x;
      if (hit_tag_ff == TAG_B1) begin
         ghost_x = (sum_x < lim_x) ? sum_x : lim_x;
      end else begin
         ghost_x = (target_x > step_x) ? (target_x - step_x) : '0;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      key_in      = key_ff;
      time_in     = time_ff;
      target_in   = target_ff;
      hit_tag_in  = hit_tag_ff;
      slot_in     = slot_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      fb_done_in  = fb_done_ff;
      purpose_in  = purpose_ff;
      sel_in      = sel_ff;
      dvd_in      = dvd_ff;
      dvs_in      = dvs_ff;
      acc_in      = acc_ff;
      m_in        = m_ff;
      wr_slot_in  = wr_slot_ff;
      wr_old_in   = wr_old_ff;
      wr_new_in   = wr_new_ff;
      wr_kt_in    = wr_kt_ff;
      wr_next_in  = wr_next_ff;
      scan_start  = 1'b0;
      scan_lru    = 1'b0;
      out_load    = 1'b0;
      for (int j = 0; j < 4; j++) begin
         cnt_in[j] = cnt_ff[j];
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               key_in     = req_page_key;
               time_in    = req_access_time;
               scan_start = 1'b1;
               state_in   = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (scan_flags.done) begin
               hit_tag_in  = scan_flags.found ? scan_flags.tag : TAG_NONE;
               slot_in     = scan_idx;
               free_vld_in = scan_flags.free_vld;
               free_idx_in = scan_free_idx;
               fb_done_in  = 1'b0;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            case (hit_tag_ff) inside
               TAG_T1, TAG_T2: begin
                  wr_slot_in = slot_ff;
                  wr_old_in  = hit_tag_ff;
                  wr_new_in  = TAG_T2;
                  wr_kt_in   = 1'b1;
                  wr_next_in = S_TRIM;
                  state_in   = S_WRITE;
               end
               TAG_B1: begin
                  if (nb1_x >= nb2_x) begin
                     m_in     = 3'd1;
                     state_in = S_GHOST;
                  end else begin
                     dvd_in   = cnt_ff[3];
                     dvs_in   = cnt_ff[2];
                     acc_in   = nb1_x;
                     m_in     = '0;
                     state_in = S_DIV;
                  end
               end
               TAG_B2: begin
                  if (nb1_x <= nb2_x) begin
                     m_in     = 3'd1;
                     state_in = S_GHOST;
                  end else begin
                     dvd_in   = cnt_ff[2];
                     dvs_in   = cnt_ff[3];
                     acc_in   = nb2_x;
                     m_in     = '0;
                     state_in = S_DIV;
                  end
               end
               default: begin
                  // miss: replacement rule picks at most one victim
                  if ((nt1_x + nb1_x) == lim_x) begin
                     sel_in     = (nt1_x < lim_x) ? TAG_B1 : TAG_T1;
                     purpose_in = P_EVICT;
                     scan_start = 1'b1;
                     scan_lru   = 1'b1;
                     state_in   = S_LRU;
                  end else if (total_x >= (c_x << 1)) begin
                     sel_in     = (nb2_x == '0) ? TAG_T2 : TAG_B2;
                     purpose_in = P_EVICT;
                     scan_start = 1'b1;
                     scan_lru   = 1'b1;
                     state_in   = S_LRU;
                  end else begin
                     state_in = S_FULL;
                  end
               end
            endcase
         end
         S_DIV: begin
            // quotient by repeated add, saturated at the step limit
            if ((XW'(dvd_ff) >= acc_ff) && (m_ff != M_MAX)) begin
               m_in   = m_ff + 1'b1;
               acc_in = acc_ff + XW'(dvs_ff);
            end else begin
               state_in = S_GHOST;
            end
         end
         S_GHOST: begin
            target_in  = CFG_BITS'(ghost_x);
            wr_slot_in = slot_ff;
            wr_old_in  = hit_tag_ff;
            wr_new_in  = TAG_T2;
            wr_kt_in   = 1'b1;
            wr_next_in = S_TRIM;
            state_in   = S_WRITE;
         end
         S_WRITE: begin
            for (int j = 0; j < 4; j++) begin
               cnt_in[j] = cnt_ff[j]
                         + CW'(wr_new_ff == TAG_BITS'(j + 1))
                         - CW'(wr_old_ff == TAG_BITS'(j + 1));
            end
            state_in = wr_next_ff;
         end
         S_LRU: begin
            if (scan_flags.done) begin
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            case (purpose_ff) inside
               P_EVICT, P_FALLBACK: begin
                  wr_new_in  = TAG_NONE;
                  wr_next_in = S_FULL;
               end
               P_TRIM1: begin
                  wr_new_in  = TAG_B1;
                  wr_next_in = S_TRIM;
               end
               default: begin
                  wr_new_in  = TAG_B2;
                  wr_next_in = S_TRIM;
               end
            endcase
            if (scan_flags.found) begin
               wr_slot_in = scan_idx;
               wr_old_in  = sel_ff;
               wr_kt_in   = 1'b0;
               state_in   = S_WRITE;
               if (((purpose_ff == P_EVICT) || (purpose_ff == P_FALLBACK)) &&
                   (!free_vld_ff || (scan_idx < free_idx_ff))) begin
                  free_vld_in = 1'b1;
                  free_idx_in = scan_idx;
               end
            end else begin
               state_in = wr_next_in;
            end
         end
         S_FULL: begin
            if (free_vld_ff) begin
               wr_slot_in = free_idx_ff;
               wr_old_in  = TAG_NONE;
               wr_new_in  = TAG_T1;
               wr_kt_in   = 1'b1;
               wr_next_in = S_TRIM;
               state_in   = S_WRITE;
            end else if (fb_done_ff) begin
               state_in = S_TRIM;
            end else begin
               // directory full after a register change
               if (nb1_x != '0) begin
                  sel_in = TAG_B1;
               end else if (nb2_x != '0) begin
                  sel_in = TAG_B2;
               end else if (nt1_x != '0) begin
                  sel_in = TAG_T1;
               end else begin
                  sel_in = TAG_T2;
               end
               fb_done_in = 1'b1;
               purpose_in = P_FALLBACK;
               scan_start = 1'b1;
               scan_lru   = 1'b1;
               state_in   = S_LRU;
            end
         end
         S_TRIM: begin
            if (nt1_x > target_x) begin
               sel_in     = TAG_T1;
               purpose_in = P_TRIM1;
               scan_start = 1'b1;
               scan_lru   = 1'b1;
               state_in   = S_LRU;
            end else if (nt2_x > t2cap_x) begin
               sel_in     = TAG_T2;
               purpose_in = P_TRIM2;
               scan_start = 1'b1;
               scan_lru   = 1'b1;
               state_in   = S_LRU;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         target_ff <= '0;
         for (int j = 0; j < 4; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         target_ff <= target_in;
         for (int j = 0; j < 4; j++) begin
            cnt_ff[j] <= cnt_in[j];
         end
      end
      key_ff      <= key_in;
      time_ff     <= time_in;
      hit_tag_ff  <= hit_tag_in;
      slot_ff     <= slot_in;
      free_vld_ff <= free_vld_in;
      free_idx_ff <= free_idx_in;
      fb_done_ff  <= fb_done_in;
      purpose_ff  <= purpose_in;
      sel_ff      <= sel_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      acc_ff      <= acc_in;
      m_ff        <= m_in;
      wr_slot_ff  <= wr_slot_in;
      wr_old_ff   <= wr_old_in;
      wr_new_ff   <= wr_new_in;
      wr_kt_ff    <= wr_kt_in;
      wr_next_ff  <= wr_next_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_hit_ff    <= (hit_tag_ff == TAG_T1) || (hit_tag_ff == TAG_T2);
         rsp_found_ff  <= hit_tag_ff;
         rsp_target_ff <= target_ff;
      end
   end

   // directory port selection
   always_comb begin
      dir_kt_we  = 1'b0;
      dir_tag_we = 1'b0;
      dir_wtag   = wr_new_ff;
      dir_addr   = scan_addr;
      if (state_ff == S_CLEAR) begin
         dir_addr   = clr_ff;
         dir_tag_we = 1'b1;
         dir_wtag   = TAG_NONE;
      end else if (state_ff == S_WRITE) begin
         dir_addr   = wr_slot_ff;
         dir_tag_we = 1'b1;
         dir_kt_we  = wr_kt_ff;
      end
   end

   arp_dir #(
      .SLOTS     (SLOTS),
      .KEY_BITS  (KEY_BITS),
      .TIME_BITS (TIME_BITS),
      .AW        (AW)
   ) u_dir (
      .clock   (clock),
      .addr    (dir_addr),
      .kt_we   (dir_kt_we),
      .tag_we  (dir_tag_we),
      .wkey    (key_ff),
      .wtime   (time_ff),
      .wtag    (dir_wtag),
      .rd_key  (rd_key),
      .rd_time (rd_time),
      .rd_tag  (rd_tag)
   );

   arp_scan #(
      .SLOTS     (SLOTS),
      .KEY_BITS  (KEY_BITS),
      .TIME_BITS (TIME_BITS),
      .AW        (AW)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .lru_mode (scan_lru),
      .sel_tag  (sel_in),
      .key      (key_ff),
      .rd_key   (rd_key),
      .rd_time  (rd_time),
      .rd_tag   (rd_tag),
      .addr     (scan_addr),
      .flags    (scan_flags),
      .idx      (scan_idx),
      .free_idx (scan_free_idx)
   );

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_hit       = rsp_hit_ff;
   assign rsp_found_in      = rsp_found_ff;
   assign rsp_recent_target = rsp_target_ff;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import arp_pkg::*;

   localparam int SLOTS = 2 * CAPACITY_DEF;
   localparam int PHASES = 9;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int LONG_HOLD = 3000;

   typedef logic [KEY_BITS_DEF-1:0]  key_type;
   typedef logic [TIME_BITS_DEF-1:0] stamp_type;

   typedef struct packed {
      logic                was_hit;
      logic [TAG_BITS-1:0] found_in;
      logic [CFG_BITS-1:0] recent_target;
   } access_result_type;

   typedef struct {
      key_type           key;
      stamp_type         stamp;
      bit                typed;
      access_result_type want;
   } access_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   key_type             req_page_key = '0;
   stamp_type           req_access_time = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_was_hit;
   logic [TAG_BITS-1:0] rsp_found_in;
   logic [CFG_BITS-1:0] rsp_recent_target;
   logic                csr_write = 1'b0;
   logic                csr_index = 1'b0;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   // shadow copy of the directory
   key_type             dir_key  [SLOTS];
   stamp_type           dir_time [SLOTS];
   logic [TAG_BITS-1:0] dir_tag  [SLOTS];
   int unsigned         tag_count [4];
   int unsigned         target_share;
   int unsigned         cache_entries_reg;
   int unsigned         recency_limit_reg;

   access_result_type pending_results [$];
   int fail_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int ghost_hits = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit long_hold_req = 1'b0;
   bit hold_used = 1'b0;
   int hold_cycles = 0;

   adaptive_replacement_policy dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_page_key(req_page_key), .req_access_time(req_access_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_was_hit(rsp_was_hit), .rsp_found_in(rsp_found_in),
      .rsp_recent_target(rsp_recent_target),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned count_in(logic [TAG_BITS-1:0] tag);
      return tag_count[(tag - 1) & 3];
   endfunction

   function automatic void set_tag(int slot, logic [TAG_BITS-1:0] tag);
      if (dir_tag[slot] != TAG_NONE) tag_count[(dir_tag[slot] - 1) & 3]--;
      if (tag != TAG_NONE) tag_count[(tag - 1) & 3]++;
      dir_tag[slot] = tag;
   endfunction

   // oldest entry of a list by (time, key)
   function automatic int oldest_in(logic [TAG_BITS-1:0] tag);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (dir_tag[i] != tag) continue;
         if (best < 0 || dir_time[i] < dir_time[best] ||
             (dir_time[i] == dir_time[best] && dir_key[i] < dir_key[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic void move_oldest(logic [TAG_BITS-1:0] from, logic [TAG_BITS-1:0] to);
      int i;
      i = oldest_in(from);
      if (i >= 0) set_tag(i, to);
   endfunction

   function automatic int first_free();
      int i;
      for (i = 0; i < SLOTS && dir_tag[i] != TAG_NONE; i++) ;
      return i;
   endfunction

   function automatic int unsigned ghost_step(int unsigned m);
      return (m >= STEP_LOG_MAX) ? STEP_SAT : (1 << m);
   endfunction

   // one page access through the replacement policy
   function automatic access_result_type predict_access(key_type key, stamp_type stamp);
      access_result_type r;
      int unsigned c, lim, nb1, nb2, nt1, total, step, t2cap;
      logic [TAG_BITS-1:0] tag;
      int slot;
      c = cache_entries_reg;
      lim = recency_limit_reg;
      if (c < 1) c = 1;
      if (c > CAPACITY_DEF) c = CAPACITY_DEF;
      if (lim < 1) lim = 1;
      if (lim > c) lim = c;
      tag = TAG_NONE;
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
         if (dir_tag[i] != TAG_NONE && dir_key[i] == key) begin
            slot = i;
            tag = dir_tag[i];
            break;
         end
      nb1 = count_in(TAG_B1);
      nb2 = count_in(TAG_B2);
      if (tag == TAG_T1 || tag == TAG_T2) begin
         set_tag(slot, TAG_T2);
         dir_time[slot] = stamp;
      end else if (tag == TAG_B1) begin
         step = ghost_step(nb1 >= nb2 ? 1 : nb2 / nb1);
         target_share = (target_share + step < lim) ? target_share + step : lim;
         set_tag(slot, TAG_T2);
         dir_time[slot] = stamp;
      end else if (tag == TAG_B2) begin
         step = ghost_step(nb1 <= nb2 ? 1 : nb1 / nb2);
         target_share = (target_share > step) ? target_share - step : 0;
         set_tag(slot, TAG_T2);
         dir_time[slot] = stamp;
      end else begin
         nt1 = count_in(TAG_T1);
         total = nt1 + count_in(TAG_T2) + nb1 + nb2;
         if (nt1 + nb1 == lim) begin
            if (nt1 < lim) move_oldest(TAG_B1, TAG_NONE);
            else move_oldest(TAG_T1, TAG_NONE);
         end else if (total >= 2 * c) begin
            if (nb2 == 0) move_oldest(TAG_T2, TAG_NONE);
            else move_oldest(TAG_B2, TAG_NONE);
         end
         slot = first_free();
         // directory full after a register change
         if (slot >= SLOTS) begin
            if (count_in(TAG_B1) != 0) move_oldest(TAG_B1, TAG_NONE);
            else if (count_in(TAG_B2) != 0) move_oldest(TAG_B2, TAG_NONE);
            else if (count_in(TAG_T1) != 0) move_oldest(TAG_T1, TAG_NONE);
            else move_oldest(TAG_T2, TAG_NONE);
            slot = first_free();
         end
         if (slot < SLOTS) begin
            dir_key[slot] = key;
            dir_time[slot] = stamp;
            set_tag(slot, TAG_T1);
         end
      end
      // trim resident lists into the ghosts
      while (count_in(TAG_T1) > target_share) move_oldest(TAG_T1, TAG_B1);
      t2cap = (c > target_share) ? c - target_share : 0;
      while (count_in(TAG_T2) > t2cap) move_oldest(TAG_T2, TAG_B2);
      r.was_hit = (tag == TAG_T1 || tag == TAG_T2);
      r.found_in = tag;
      r.recent_target = target_share[CFG_BITS-1:0];
      return r;
   endfunction

   // offer one access word and wait for it to be taken
   task automatic send_access(key_type key, stamp_type stamp, bit typed,
                              access_result_type want);
      access_result_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_page_key = key;
      req_access_time = stamp;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      r = predict_access(key, stamp);
      if (r.found_in == TAG_B1 || r.found_in == TAG_B2) ghost_hits++;
      pending_results.push_back(typed ? want : r);
      words_sent++;
   endtask

   // register write, only once the block has drained
   task automatic write_reg(logic idx, logic [CFG_BITS-1:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (20) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CSR_CACHE_ENTRIES) cache_entries_reg = 32'(value);
      else recency_limit_reg = 32'(value);
   endtask

   // receiver stall, with one long hold-off counted here
   always @(negedge clock) begin
      if (long_hold_req && !hold_used) begin
         hold_used <= 1'b1;
         hold_cycles <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      access_result_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
         end else begin
            w = pending_results.pop_front();
            words_checked++;
            if (rsp_was_hit !== w.was_hit) begin
               $error("was_hit: expected %0d actual %0d", w.was_hit, rsp_was_hit);
               fail_count++;
            end
            if (rsp_found_in !== w.found_in) begin
               $error("found_in: expected %0d actual %0d", w.found_in, rsp_found_in);
               fail_count++;
            end
            if (rsp_recent_target !== w.recent_target) begin
               $error("recent_target: expected %0d actual %0d",
                      w.recent_target, rsp_recent_target);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      access_row_type rows [$];
      access_row_type row;
      access_result_type none;
      int cfg_c [PHASES];
      int cfg_l [PHASES];
      key_type base, key;
      stamp_type clk_stamp, stamp;
      int span, pick;

      cfg_c = '{64, 1, 0, 127, 8, 16, 3, 32, 5};
      cfg_l = '{64, 1, 0, 127, 3, 40, 1, 16, 5};
      none = '0;
      for (int i = 0; i < SLOTS; i++) begin
         dir_tag[i] = TAG_NONE;
         dir_key[i] = '0;
         dir_time[i] = '0;
      end
      tag_count = '{0, 0, 0, 0};
      target_share = 0;
      cache_entries_reg = CFG_RESET;
      recency_limit_reg = CFG_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // wait out the tag clearing sweep
      while (req_stall) @(negedge clock);

      // directed words: miss, recent ghost, frequent, extremes, tie on time
      rows.push_back('{48'h0, 40'h0, 1'b1, '{1'b0, TAG_NONE, 7'd0}});
      rows.push_back('{48'h0, 40'h1, 1'b1, '{1'b0, TAG_B1, 7'd2}});
      rows.push_back('{48'h0, 40'h2, 1'b1, '{1'b1, TAG_T2, 7'd2}});
      rows.push_back('{'1, '1, 1'b1, '{1'b0, TAG_NONE, 7'd2}});
      rows.push_back('{'1, 40'h3, 1'b1, '{1'b1, TAG_T1, 7'd2}});
      rows.push_back('{48'hAAAA_AAAA_AAAA, 40'h55_5555_5555, 1'b0, none});
      rows.push_back('{48'h5555_5555_5555, 40'h55_5555_5555, 1'b0, none});
      rows.push_back('{48'h1, 40'h5, 1'b0, none});
      rows.push_back('{48'h2, 40'h5, 1'b0, none});
      rows.push_back('{48'h3, 40'h5, 1'b0, none});
      rows.push_back('{48'hAAAA_AAAA_AAAA, 40'hAA_AAAA_AAAA, 1'b0, none});
      rows.push_back('{48'h5555_5555_5555, 40'h6, 1'b0, none});
      rows.push_back('{48'h1, 40'h7, 1'b0, none});
      rows.push_back('{48'h2, 40'h7, 1'b0, none});
      rows.push_back('{48'h8000_0000_0000, 40'h80_0000_0000, 1'b0, none});
      rows.push_back('{48'h3, 40'h8, 1'b0, none});
      rows.push_back('{48'h0, 40'h9, 1'b0, none});
      send_idle_pct = 31;
      recv_idle_pct = 82;
      foreach (rows[i]) begin
         row = rows[i];
         send_access(row.key, row.stamp, row.typed, row.want);
      end

      clk_stamp = 40'h100;
      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_CACHE_ENTRIES, CFG_BITS'(cfg_c[p]));
         write_reg(CSR_RECENCY_LIMIT, CFG_BITS'(cfg_l[p]));
         send_idle_pct = (p < 3) ? 31 : (p < 6) ? 82 : 0;
         recv_idle_pct = (p < 3) ? 82 : (p < 6) ? 31 : 0;
         base = KEY_BITS_DEF'({$urandom, $urandom});
         span = 2 * ((cfg_c[p] < 1) ? 1 : (cfg_c[p] > 64) ? 64 : cfg_c[p]) + 4;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while words keep coming
            if (p == 6 && n == 5) long_hold_req = 1'b1;
            // sender pause until the block has drained
            if (p == 7 && n == 25) begin
               @(negedge clock);
               req_valid = 1'b0;
               wait (pending_results.size() == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 85) key = base + $urandom_range(0, span);
            else if (pick < 93) key = KEY_BITS_DEF'({$urandom, $urandom});
            else key = base ^ (48'h1 << $urandom_range(0, 47));
            clk_stamp = clk_stamp + $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 5) stamp = TIME_BITS_DEF'({$urandom, $urandom});
            else stamp = clk_stamp;
            send_access(key, stamp, 1'b0, none);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (1000) @(posedge clock);
      $display("covered %0d access words over %0d register settings, %0d ghost hits",
               words_sent, PHASES + 1, ghost_hits);
      $display("checked %0d response words, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
